@@ design/nss_pkg.sv @@
package nss_pkg;

  localparam int MAX_STATIONS = 1024;
  localparam int IDX_W = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
  localparam int CNT_W = $clog2(MAX_STATIONS + 1);
  localparam int ID_W = 24;
  localparam int POS_W = 32;
  localparam int MAG_W = POS_W;
  localparam int SQ_W = 2 * MAG_W;
  localparam int DIST_W = SQ_W + 1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } nss_op_e;

  typedef struct packed {
    logic             load_en;
    logic             clear_en;
    logic             query_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } nss_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             pipe_busy;
  } nss_stat_t;

endpackage

@@ design/nss_ctrl.sv @@
module nss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          operation_i,
  input  nss_pkg::nss_stat_t  stat_i,
  output nss_pkg::nss_cmd_t   cmd_o,
  output logic                busy,
  output logic                result_valid_o
);
  import nss_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] addr_q;
  logic             done_q;
  logic             accept;
  logic             scan_rd;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign scan_rd = (state_q == S_SCAN) && (addr_q < stat_i.count);

  always_comb begin
    cmd_o = '0;
    if (accept) begin
      unique case (nss_op_e'(operation_i))
        OP_LOAD:  cmd_o.load_en  = 1'b1;
        OP_QUERY: cmd_o.query_en = 1'b1;
        OP_CLEAR: cmd_o.clear_en = 1'b1;
        default:  cmd_o = '0;
      endcase
    end
    cmd_o.rd_en   = scan_rd;
    cmd_o.rd_addr = addr_q[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      addr_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept && (nss_op_e'(operation_i) == OP_QUERY)) begin
            state_q <= S_SCAN;
            addr_q  <= '0;
          end
        end
        S_SCAN: begin
          if (scan_rd) begin
            addr_q <= addr_q + 1'b1;
          end else begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!stat_i.pipe_busy) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = done_q;

  a_done_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_DRAIN))
    else $error("result strobe without drain");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (addr_q < stat_i.count) && (state_q == S_SCAN))
    else $error("read beyond stored stations");

  a_no_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !(cmd_o.load_en || cmd_o.query_en || cmd_o.clear_en))
    else $error("command issued while busy");

endmodule

@@ design/nss_datapath.sv @@
module nss_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nss_pkg::nss_cmd_t               cmd_i,
  input  logic [nss_pkg::ID_W-1:0]        item_id_i,
  input  logic signed [nss_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [nss_pkg::POS_W-1:0] pos_y_i,
  output nss_pkg::nss_stat_t              stat_o,
  output logic [nss_pkg::ID_W-1:0]        query_id_o,
  output logic [nss_pkg::ID_W-1:0]        nearest_id_o,
  output logic                            table_empty_o,
  output logic                            table_overflowed_o
);
  import nss_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } entry_t;

  entry_t mem [MAX_STATIONS];

  logic [CNT_W-1:0]  count_q;
  logic              overflow_q;
  logic              full;

  logic [ID_W-1:0]   qid_q;
  logic [POS_W-1:0]  qx_q;
  logic [POS_W-1:0]  qy_q;

  entry_t            rd_q;
  logic              v0_q, v1_q, v2_q, v3_q;
  logic [ID_W-1:0]   id1_q, id2_q, id3_q;
  logic [MAG_W-1:0]  adx_q, ady_q;
  logic [SQ_W-1:0]   sx_q, sy_q;
  logic [DIST_W-1:0] sum_q;
  logic [DIST_W-1:0] best_dist_q;
  logic [ID_W-1:0]   best_id_q;
  logic              first_q;

  logic [POS_W:0]    dx, dy;
  logic [MAG_W-1:0]  adx_d, ady_d;

  assign full = (count_q == CNT_W'(MAX_STATIONS));

  // station table
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en && !full) begin
      mem[count_q[IDX_W-1:0]] <= '{id: item_id_i, x: pos_x_i, y: pos_y_i};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else begin
      if (cmd_i.clear_en) begin
        count_q <= '0;
      end else if (cmd_i.load_en) begin
        if (full) begin
          overflow_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  // query position
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_en) begin
      qid_q <= item_id_i;
      qx_q  <= pos_x_i;
      qy_q  <= pos_y_i;
    end
  end

  // absolute differences
  always_comb begin
    dx    = {rd_q.x[POS_W-1], rd_q.x} - {qx_q[POS_W-1], qx_q};
    dy    = {rd_q.y[POS_W-1], rd_q.y} - {qy_q[POS_W-1], qy_q};
    adx_d = dx[POS_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
    ady_d = dy[POS_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      first_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.rd_en;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.query_en) begin
        first_q <= 1'b1;
      end else if (v3_q) begin
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    adx_q <= adx_d;
    ady_q <= ady_d;
    id1_q <= rd_q.id;
    sx_q  <= adx_q * adx_q;
    sy_q  <= ady_q * ady_q;
    id2_q <= id1_q;
    sum_q <= {1'b0, sx_q} + {1'b0, sy_q};
    id3_q <= id2_q;
    if (cmd_i.query_en) begin
      best_id_q <= '0;
    end else if (v3_q && (first_q || (sum_q < best_dist_q))) begin
      best_id_q   <= id3_q;
      best_dist_q <= sum_q;
    end
  end

  assign stat_o.count     = count_q;
  assign stat_o.pipe_busy = v0_q || v1_q || v2_q || v3_q;

  assign query_id_o         = qid_q;
  assign nearest_id_o       = best_id_q;
  assign table_empty_o      = (count_q == '0);
  assign table_overflowed_o = overflow_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_STATIONS))
    else $error("station count beyond capacity");

  a_full_load_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_en && full) |=> overflow_q && $stable(count_q))
    else $error("load into full table not flagged");

  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |=> overflow_q)
    else $error("overflow flag dropped");

  a_first_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !cmd_i.query_en) |=> !first_q)
    else $error("first candidate not consumed");

endmodule

@@ design/nearest_station_search.sv @@
// nearest station search over a table of up to MAX_STATIONS stations
// command channel: operation_i, item_id_i, pos_x_i, pos_y_i are taken at a rising
// edge where start is high and busy is low; that beat is one command
//   load: appends a station; when the table is full it is dropped and
//   the sticky overflow flag is set
//   clear: empties the table; the overflow flag stays
//   query: scans every stored station, one table read per cycle, through a
//   four-stage distance pipeline (difference, square, sum, compare)
//   operation code 3 is taken and ignored
// result channel: result_valid_o is high for exactly one cycle per query, with
// query_id_o, nearest_id_o, table_empty_o and table_overflowed_o valid in it
// a query keeps busy high through its scan and drain, also on an empty table, and
// its result beat follows in the cycle where busy drops; loads and clears do not raise busy
// the scan rate is set by the single read port of the station table
// on an equal distance the earliest loaded station wins; on an empty table the
// result beat carries nearest_id_o 0 and table_empty_o 1
// the receiver cannot hold off a result beat: it must take it in that cycle
// reset clears the station count, the overflow flag and all control state;
// the table contents are not cleared and need no clearing pass
module nearest_station_search (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      operation_i,
  input  logic [nss_pkg::ID_W-1:0]        item_id_i,
  input  logic signed [nss_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [nss_pkg::POS_W-1:0] pos_y_i,
  output logic                            result_valid_o,
  output logic [nss_pkg::ID_W-1:0]        query_id_o,
  output logic [nss_pkg::ID_W-1:0]        nearest_id_o,
  output logic                            table_empty_o,
  output logic                            table_overflowed_o
);
  import nss_pkg::*;

  nss_cmd_t  cmd;
  nss_stat_t stat;

  nss_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .operation_i    (operation_i),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  nss_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .item_id_i          (item_id_i),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .stat_o             (stat),
    .query_id_o         (query_id_o),
    .nearest_id_o       (nearest_id_o),
    .table_empty_o      (table_empty_o),
    .table_overflowed_o (table_overflowed_o)
  );

endmodule
